>>> hw/rtl/cidp_pkg.sv
// ----------------------------------------------------------------------------
// cidp_pkg
// Shared types, sizes and CRC helper for the chunked identity provisioning
// registers.
// ----------------------------------------------------------------------------
package cidp_pkg;

  // sizes of the staging window
  localparam int unsigned CHUNK_COUNT = 4;
  localparam int unsigned CHUNK_BYTES = 4;
  localparam int unsigned ID_BYTES    = 16;

  localparam int unsigned CHUNK_W = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int unsigned CNT_W   = $clog2(ID_BYTES);

  // crc-8, msb first, no reflection
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam logic [CHUNK_COUNT-1:0] ALL_PRESENT = {CHUNK_COUNT{1'b1}};

  // operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TAKE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // input transaction payload
  typedef struct packed {
    op_e         operation;
    logic [7:0]  register_address;
    logic [31:0] write_data;
    logic [7:0]  byte_count;
    logic        identity_locked;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic        commit_accepted;
    logic        commit_taken;
    logic [63:0] identity_low;
    logic [63:0] identity_high;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic crc_start;
    logic crc_step;
    logic apply;
  } cidp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_crc;
    logic crc_last;
    logic out_free;
  } cidp_status_t;

  // one byte through the crc register, eight bit steps
  function automatic logic [7:0] crc8_byte(logic [7:0] crc_in, logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/chunked_id_provisioning_regs.sv
// ----------------------------------------------------------------------------
// chunked_id_provisioning_regs
// Register-mapped staging of a 16-byte identity written as four chunk
// transactions and a checked commit, with take and clear operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one transaction (bus write,
//   take or clear). Output channel out_valid_o/out_ready_i returns exactly
//   one result per input transaction, in order.
//   cfg_we_i/cfg_wdata_i set the bus address of chunk 0; write it only
//   while the block is idle.
//   Flow: an accepted transaction is registered and decoded, and its result
//   is then written to the output register; a commit whose mask and low
//   bytes pass first runs the crc over the stage, one stage byte per cycle.
//   A new transaction is taken only after the result of the last one has
//   been written to the output register.
//   in_ready_o is high only while the sequencer waits for work.
//   A result waits in the output register while the receiver stalls; the
//   next transaction may be accepted meanwhile, and its result is held
//   back until that register drains.
//   Reset clears the stage, the present mask, the committed identity, the
//   pending flag and the base address; the block is ready right away.
// ----------------------------------------------------------------------------
module chunked_id_provisioning_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cidp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cidp_pkg::out_item_t out_data_o
);
  import cidp_pkg::*;

  cidp_cmd_t    cmd;
  cidp_status_t status;

  // sequencer
  cidp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  cidp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

>>> hw/rtl/cidp_ctrl.sv
// ----------------------------------------------------------------------------
// cidp_ctrl
// Sequencer: accepts a transaction, lets the datapath decode it, steps the
// crc over the stage for a commit, then hands the result to the output.
// ----------------------------------------------------------------------------
module cidp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cidp_pkg::cidp_status_t status_i,
  output cidp_pkg::cidp_cmd_t    cmd_o
);
  import cidp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_CRC    = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.need_crc) begin
          cmd_o.crc_start = 1'b1;
          state_d         = ST_CRC;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_CRC: begin
        cmd_o.crc_step = 1'b1;
        if (status_i.crc_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // checks
  a_apply_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |-> status_i.out_free)
    else $error("result applied while output register busy");

  a_crc_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRC && status_i.crc_last) |=> state_q == ST_RESULT)
    else $error("crc pass did not end on last byte");

  a_load_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_DECODE && !in_ready_o))
    else $error("accepted transaction not decoded");

endmodule

>>> hw/rtl/cidp_dp.sv
// ----------------------------------------------------------------------------
// cidp_dp
// Datapath: base address register, request register, stage and committed
// identity, present mask, byte-serial crc-8 and the result register.
// ----------------------------------------------------------------------------
module cidp_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  input  cidp_pkg::in_item_t     in_data_i,
  output cidp_pkg::out_item_t    out_data_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  cidp_pkg::cidp_cmd_t    cmd_i,
  output cidp_pkg::cidp_status_t status_o
);
  import cidp_pkg::*;

  logic [7:0]             base_q;
  in_item_t               req_q;
  logic [7:0]             stage_q [ID_BYTES];
  logic [7:0]             stage_d [ID_BYTES];
  logic [7:0]             commit_q [ID_BYTES];
  logic [7:0]             commit_d [ID_BYTES];
  logic [CHUNK_COUNT-1:0] mask_q, mask_d;
  logic                   pending_q, pending_d;
  logic [7:0]             crc_q, crc_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  out_item_t              out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic [7:0]         addr_off;
  logic               in_window;
  logic               write_ok;
  logic               is_chunk;
  logic [CHUNK_W-1:0] chunk;
  logic               need_crc;
  logic               commit_ok;

  // address decode of the held request
  always_comb begin
    addr_off  = req_q.register_address - base_q;
    in_window = (req_q.register_address >= base_q) &&
                ({1'b0, addr_off} <= 9'(CHUNK_COUNT));
    write_ok  = (req_q.operation == OP_WRITE) && in_window &&
                !req_q.identity_locked && (req_q.byte_count == 8'(CHUNK_BYTES));
    is_chunk  = {1'b0, addr_off} < 9'(CHUNK_COUNT);
    chunk     = addr_off[CHUNK_W-1:0];
    need_crc  = write_ok && !is_chunk && (mask_q == ALL_PRESENT) &&
                (req_q.write_data[23:0] == 24'd0);
    commit_ok = need_crc && (req_q.write_data[31:24] == crc_q);
  end

  assign status_o.need_crc = need_crc;
  assign status_o.crc_last = (cnt_q == CNT_W'(ID_BYTES - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // crc over the stage, one byte per cycle
  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (cmd_i.crc_start) begin
      crc_d = 8'h00;
      cnt_d = '0;
    end else if (cmd_i.crc_step) begin
      crc_d = crc8_byte(crc_q, stage_q[cnt_q]);
      cnt_d = cnt_q + 1'b1;
    end
  end

  // state update and result of the held request
  always_comb begin
    stage_d     = stage_q;
    commit_d    = commit_q;
    mask_d      = mask_q;
    pending_d   = pending_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.apply) begin
      out_d       = '0;
      out_valid_d = 1'b1;
      unique case (req_q.operation)
        OP_CLEAR: begin
          for (int j = 0; j < ID_BYTES; j++) begin
            stage_d[j]  = 8'h00;
            commit_d[j] = 8'h00;
          end
          mask_d    = '0;
          pending_d = 1'b0;
        end
        OP_TAKE: begin
          if (pending_q) begin
            out_d.commit_taken = 1'b1;
            for (int k = 0; k < 8; k++) begin
              if (k < ID_BYTES) begin
                out_d.identity_low[8*k +: 8] = commit_q[k];
              end
              if (8 + k < ID_BYTES) begin
                out_d.identity_high[8*k +: 8] = commit_q[8 + k];
              end
            end
            for (int j = 0; j < ID_BYTES; j++) begin
              commit_d[j] = 8'h00;
            end
            pending_d = 1'b0;
          end
        end
        OP_WRITE: begin
          if (write_ok && is_chunk) begin
            // chunk 0 starts a fresh stage
            if (chunk == '0) begin
              for (int j = 0; j < ID_BYTES; j++) begin
                stage_d[j] = 8'h00;
              end
              mask_d = '0;
            end
            for (int j = 0; j < ID_BYTES; j++) begin
              if ((j / CHUNK_BYTES) == int'(chunk)) begin
                stage_d[j] = req_q.write_data[8*(j % CHUNK_BYTES) +: 8];
              end
            end
            for (int c = 0; c < CHUNK_COUNT; c++) begin
              if (c == int'(chunk)) begin
                mask_d[c] = 1'b1;
              end
            end
          end else if (write_ok) begin
            // commit register: pass or fail, the stage is dropped
            if (commit_ok) begin
              commit_d              = stage_q;
              pending_d             = 1'b1;
              out_d.commit_accepted = 1'b1;
            end
            for (int j = 0; j < ID_BYTES; j++) begin
              stage_d[j] = 8'h00;
            end
            mask_d = '0;
          end
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= 8'h00;
      mask_q      <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < ID_BYTES; j++) begin
        stage_q[j]  <= 8'h00;
        commit_q[j] <= 8'h00;
      end
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      mask_q      <= mask_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
      stage_q     <= stage_d;
      commit_q    <= commit_d;
    end
  end

  // request, crc and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    crc_q <= crc_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  // checks
  a_pending_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pending_q) |-> $past(cmd_i.apply && commit_ok))
    else $error("pending identity set without a passing commit");

  a_taken_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && out_d.commit_taken) |=> !pending_q)
    else $error("identity still pending after take");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("result dropped or changed while receiver stalled");

endmodule
